// ===== design/fsts_pkg.sv =====
// Shared types and constants for the floor span texture set-up block.
`default_nettype none
package fsts_pkg;
   localparam int unsigned WORD_W  = 32;   // 16.16 word
   localparam int unsigned DY_W    = 9;    // row distance from the horizon
   localparam int unsigned DX_W    = 11;   // signed column offset
   localparam int unsigned LIGHT_W = 7;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PLANE_HEIGHT  = 3'd0,
      CSR_EYE_X         = 3'd1,
      CSR_EYE_Y         = 3'd2,
      CSR_EYE_SINE      = 3'd3,
      CSR_EYE_COSINE    = 3'd4,
      CSR_MIDDLE_COLUMN = 3'd5,
      CSR_HORIZON_ROW   = 3'd6,
      CSR_FIXED_MAP_ON  = 3'd7
   } csr_index_type;

   // one entry into the step divider: two dividends sharing one divisor
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] mag_x;
      logic              neg_x;
      logic [WORD_W-1:0] mag_y;
      logic              neg_y;
      logic [DY_W-1:0]   divisor;
   } div_in_type;

   // signed quotients leaving the divider
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] quo_x;
      logic [WORD_W-1:0] quo_y;
   } div_out_type;
endpackage
`default_nettype wire

// ===== design/fsts_div.sv =====
// Pipelined two-lane restoring divider for the per-pixel texture steps.
`default_nettype none
module fsts_div #(
   parameter int PW = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire fsts_pkg::div_in_type din,
   input  wire logic [PW-1:0]        pay_in,
   output fsts_pkg::div_out_type     dout,
   output logic [PW-1:0]             pay_out
);
   import fsts_pkg::*;

   localparam int BPS  = 4;               // quotient bits per stage
   localparam int NSTG = WORD_W / BPS;

   logic              valid_ff [NSTG];
   logic [WORD_W-1:0] numx_ff  [NSTG];
   logic [WORD_W-1:0] numy_ff  [NSTG];
   logic [DY_W-1:0]   remx_ff  [NSTG];
   logic [DY_W-1:0]   remy_ff  [NSTG];
   logic              negx_ff  [NSTG];
   logic              negy_ff  [NSTG];
   logic [DY_W-1:0]   dvs_ff   [NSTG];
   logic [PW-1:0]     pay_ff   [NSTG];

   logic [WORD_W-1:0] numx_in  [NSTG];
   logic [WORD_W-1:0] numy_in  [NSTG];
   logic [DY_W-1:0]   remx_in  [NSTG];
   logic [DY_W-1:0]   remy_in  [NSTG];

   logic              ovalid_ff;
   logic [WORD_W-1:0] qx_ff, qy_ff;
   logic [PW-1:0]     opay_ff;

   // BPS restoring steps per stage on both lanes
   always_comb begin
      logic [WORD_W-1:0] nx, ny;
      logic [DY_W:0]     rx, ry;
      logic [DY_W-1:0]   d;
      for (int s = 0; s < NSTG; s++) begin
         if (s == 0) begin
            nx = din.mag_x;
            ny = din.mag_y;
            rx = '0;
            ry = '0;
            d  = din.divisor;
         end else begin
            nx = numx_ff[s-1];
            ny = numy_ff[s-1];
            rx = {1'b0, remx_ff[s-1]};
            ry = {1'b0, remy_ff[s-1]};
            d  = dvs_ff[s-1];
         end
         for (int b = 0; b < BPS; b++) begin
            rx = {rx[DY_W-1:0], nx[WORD_W-1]};
            nx = {nx[WORD_W-2:0], 1'b0};
            if (rx >= {1'b0, d}) begin
               rx    = rx - {1'b0, d};
               nx[0] = 1'b1;
            end
            ry = {ry[DY_W-1:0], ny[WORD_W-1]};
            ny = {ny[WORD_W-2:0], 1'b0};
            if (ry >= {1'b0, d}) begin
               ry    = ry - {1'b0, d};
               ny[0] = 1'b1;
            end
         end
         numx_in[s] = nx;
         numy_in[s] = ny;
         remx_in[s] = rx[DY_W-1:0];
         remy_in[s] = ry[DY_W-1:0];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) valid_ff[s] <= 1'b0;
         ovalid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= din.valid;
         for (int s = 1; s < NSTG; s++) valid_ff[s] <= valid_ff[s-1];
         ovalid_ff <= valid_ff[NSTG-1];
      end
      if (en) begin
         for (int s = 0; s < NSTG; s++) begin
            numx_ff[s] <= numx_in[s];
            numy_ff[s] <= numy_in[s];
            remx_ff[s] <= remx_in[s];
            remy_ff[s] <= remy_in[s];
         end
         negx_ff[0] <= din.neg_x;
         negy_ff[0] <= din.neg_y;
         dvs_ff[0]  <= din.divisor;
         pay_ff[0]  <= pay_in;
         for (int s = 1; s < NSTG; s++) begin
            negx_ff[s] <= negx_ff[s-1];
            negy_ff[s] <= negy_ff[s-1];
            dvs_ff[s]  <= dvs_ff[s-1];
            pay_ff[s]  <= pay_ff[s-1];
         end
         // apply quotient sign: truncation toward zero
         qx_ff   <= negx_ff[NSTG-1] ? (~numx_ff[NSTG-1] + 1'b1) : numx_ff[NSTG-1];
         qy_ff   <= negy_ff[NSTG-1] ? (~numy_ff[NSTG-1] + 1'b1) : numy_ff[NSTG-1];
         opay_ff <= pay_ff[NSTG-1];
      end
   end

   assign dout.valid = ovalid_ff;
   assign dout.quo_x = qx_ff;
   assign dout.quo_y = qy_ff;
   assign pay_out    = opay_ff;
endmodule
`default_nettype wire

// ===== design/floor_span_texture_setup_top.sv =====
// Top level of the floor span texture set-up pipeline.
// Usage:
//  - req_ channel: one span per transaction; req_tdata holds row, span_first,
//    span_last, row_slope. A span on the horizon row is consumed and gives
//    no result.
//  - rsp_ channel: one result per non-horizon span; rsp_tdata holds the span
//    pass-through, texture starts and steps and light index; rsp_tuser holds
//    use_fixed_map.
//  - csr_ port: write-only registers, written while the block is idle.
// From request to result a span passes two set-up stages (16.16
// products, step dividend magnitudes), eight divider stages resolving four
// quotient bits each plus a sign stage, one stage of step and rotation
// products and one final sum stage. Throughput is one span per cycle while the receiver does not stall.
// Reset clears all stage valid bits and loads the register reset values.
// When the receiver stalls a held result, the whole pipeline holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module floor_span_texture_setup_top #(
   parameter int LIGHT_SHIFT  = 20,
   parameter int LIGHT_LEVELS = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // row[8:0], span_first[18:9], span_last[28:19], row_slope[59:29]
   input  wire logic [63:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_row[8:0], out_first[18:9], out_last[28:19], tex_x_start[60:29],
   // tex_y_start[92:61], tex_x_step[124:93], tex_y_step[156:125],
   // light_index[163:157]
   output logic [167:0]      rsp_tdata,
   // use_fixed_map[0]
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import fsts_pkg::*;

   localparam int PW = 9 + 10 + 10 + DX_W + WORD_W + LIGHT_W;

   // configuration registers
   logic [30:0] plane_height_ff;
   logic [31:0] eye_x_ff, eye_y_ff;
   logic [17:0] eye_sine_ff, eye_cosine_ff;
   logic [9:0]  middle_column_ff;
   logic [8:0]  horizon_row_ff;
   logic        fixed_map_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_height_ff  <= '0;
         eye_x_ff         <= '0;
         eye_y_ff         <= '0;
         eye_sine_ff      <= '0;
         eye_cosine_ff    <= 18'd65536;
         middle_column_ff <= 10'd160;
         horizon_row_ff   <= 9'd100;
         fixed_map_on_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PLANE_HEIGHT:  plane_height_ff  <= csr_wdata[30:0];
            CSR_EYE_X:         eye_x_ff         <= csr_wdata;
            CSR_EYE_Y:         eye_y_ff         <= csr_wdata;
            CSR_EYE_SINE:      eye_sine_ff      <= csr_wdata[17:0];
            CSR_EYE_COSINE:    eye_cosine_ff    <= csr_wdata[17:0];
            CSR_MIDDLE_COLUMN: middle_column_ff <= csr_wdata[9:0];
            CSR_HORIZON_ROW:   horizon_row_ff   <= csr_wdata[8:0];
            CSR_FIXED_MAP_ON:  fixed_map_on_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // global advance: the output register is free or being taken
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // request fields
   logic [8:0]  in_row;
   logic [9:0]  in_first, in_last;
   logic [30:0] in_slope;
   assign in_row   = req_tdata[8:0];
   assign in_first = req_tdata[18:9];
   assign in_last  = req_tdata[28:19];
   assign in_slope = req_tdata[59:29];

   // stage 1: row distance, column offset, 16.16 products
   logic        s1_valid_ff;
   logic [8:0]  s1_row_ff;
   logic [9:0]  s1_first_ff, s1_last_ff;
   logic signed [DX_W-1:0] s1_dx_ff;
   logic [DY_W-1:0] s1_dy_ff;
   logic [61:0] s1_pdist_ff;
   logic signed [49:0] s1_pxs_ff, s1_pys_ff;
   logic [DY_W-1:0] dy_in;
   logic signed [31:0] ph_s;

   assign dy_in = (horizon_row_ff >= in_row) ? (horizon_row_ff - in_row)
                                             : (in_row - horizon_row_ff);
   assign ph_s  = signed'({1'b0, plane_height_ff});

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_tvalid && (dy_in != '0);
      if (adv) begin
         s1_row_ff   <= in_row;
         s1_first_ff <= in_first;
         s1_last_ff  <= in_last;
         s1_dx_ff    <= signed'({1'b0, in_first} - {1'b0, middle_column_ff});
         s1_dy_ff    <= dy_in;
         s1_pdist_ff <= {31'd0, plane_height_ff} * {31'd0, in_slope};
         s1_pxs_ff   <= 50'(signed'(eye_sine_ff) * ph_s);
         s1_pys_ff   <= 50'(signed'(eye_cosine_ff) * ph_s);
      end
   end

   // stage 2: shift products, dividend magnitudes, light index
   logic [31:0] dist_w, xs_w, ys_w, lsh_w;
   logic [LIGHT_W-1:0] lidx_w;
   div_in_type s2_div_ff;
   logic [PW-1:0] s2_pay_ff;

   assign dist_w = s1_pdist_ff[47:16];
   assign xs_w   = s1_pxs_ff[47:16];
   assign ys_w   = s1_pys_ff[47:16];
   assign lsh_w  = dist_w >> LIGHT_SHIFT;

   always_comb begin
      if (fixed_map_on_ff) lidx_w = '0;
      else if (lsh_w >= 32'(LIGHT_LEVELS)) lidx_w = LIGHT_W'(LIGHT_LEVELS - 1);
      else lidx_w = lsh_w[LIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s2_div_ff.valid <= 1'b0;
      else if (adv) s2_div_ff.valid <= s1_valid_ff;
      if (adv) begin
         s2_div_ff.mag_x   <= xs_w[31] ? (~xs_w + 1'b1) : xs_w;
         s2_div_ff.neg_x   <= xs_w[31];
         s2_div_ff.mag_y   <= ys_w[31] ? (~ys_w + 1'b1) : ys_w;
         s2_div_ff.neg_y   <= ys_w[31];
         s2_div_ff.divisor <= s1_dy_ff;
         s2_pay_ff <= {s1_row_ff, s1_first_ff, s1_last_ff, s1_dx_ff, dist_w, lidx_w};
      end
   end

   // step division
   div_out_type dq;
   logic [PW-1:0] d_pay;

   fsts_div #(.PW(PW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .din     (s2_div_ff),
      .pay_in  (s2_pay_ff),
      .dout    (dq),
      .pay_out (d_pay)
   );

   logic [8:0]  d_row;
   logic [9:0]  d_first, d_last;
   logic signed [DX_W-1:0] d_dx;
   logic [31:0] d_dist;
   logic [LIGHT_W-1:0] d_lidx;
   assign {d_row, d_first, d_last, d_dx, d_dist, d_lidx} = d_pay;

   // stage M: rotation and step products
   logic        m_valid_ff;
   logic [8:0]  m_row_ff;
   logic [9:0]  m_first_ff, m_last_ff;
   logic [LIGHT_W-1:0] m_lidx_ff;
   logic [31:0] m_xstep_ff, m_ystep_ff, m_px_ff, m_py_ff;
   logic signed [49:0] m_pc_ff, m_ps_ff;
   logic signed [42:0] px_w, py_w;

   assign px_w = 43'(d_dx * signed'(dq.quo_x));
   assign py_w = 43'(d_dx * signed'(dq.quo_y));

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else if (adv) m_valid_ff <= dq.valid;
      if (adv) begin
         m_row_ff   <= d_row;
         m_first_ff <= d_first;
         m_last_ff  <= d_last;
         m_lidx_ff  <= d_lidx;
         m_xstep_ff <= dq.quo_x;
         m_ystep_ff <= dq.quo_y;
         m_px_ff    <= px_w[31:0];
         m_py_ff    <= py_w[31:0];
         m_pc_ff    <= 50'(signed'(eye_cosine_ff) * signed'(d_dist));
         m_ps_ff    <= 50'(signed'(eye_sine_ff) * signed'(d_dist));
      end
   end

   // final stage: texture start sums into the output register
   logic [31:0] xs_sum_in, ys_sum_in;
   logic [163:0] out_data_ff;
   logic         out_user_ff;

   assign xs_sum_in = eye_x_ff + m_pc_ff[47:16] + m_px_ff;
   assign ys_sum_in = 32'd0 - eye_y_ff - m_ps_ff[47:16] + m_py_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= m_valid_ff;
      if (adv) begin
         out_data_ff <= {m_lidx_ff, m_ystep_ff, m_xstep_ff, ys_sum_in, xs_sum_in,
                         m_last_ff, m_first_ff, m_row_ff};
         out_user_ff <= fixed_map_on_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_data_ff};
   assign rsp_tuser  = out_user_ff;
endmodule
`default_nettype wire

// ===== design/fsts_checker.sv =====
// Port-level checker for the floor span texture set-up block, with its bind.
`default_nettype none
module fsts_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [167:0] rsp_tdata,
   input wire logic [0:0]   rsp_tuser
);
   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // a receiver stall holds the whole pipeline, input side included
   a_stall_prop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // fixed colormap forces a zero light index
   a_fixed_light: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[163:157] == 7'd0)
      else $error("light index set with fixed colormap");
endmodule

bind floor_span_texture_setup_top fsts_checker u_fsts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
